// ===== rtl/core/ipv6hc_pkg.sv =====
// package for the ipv6 header decompressor: beat types, phase codes,
// status codes and configuration register indexes; no dependencies
`timescale 1ns / 1ps

package ipv6hc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_frame;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] flow_word;
    logic [15:0] payload_length;
    logic [7:0]  next_header;
    logic [7:0]  hop_limit;
    logic [63:0] source_high;
    logic [63:0] source_low;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
  } out_t;

  // parse phases of one frame
  localparam logic [3:0] PhB0    = 4'd0;
  localparam logic [3:0] PhB1    = 4'd1;
  localparam logic [3:0] PhFlow  = 4'd2;
  localparam logic [3:0] PhNh    = 4'd3;
  localparam logic [3:0] PhHop   = 4'd4;
  localparam logic [3:0] PhSrc   = 4'd5;
  localparam logic [3:0] PhDst   = 4'd6;
  localparam logic [3:0] PhPay   = 4'd7;
  localparam logic [3:0] PhDrain = 4'd8;

  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StBadPattern  = 3'd1;
  localparam logic [2:0] StUnsupported = 3'd2;
  localparam logic [2:0] StMulticast   = 3'd3;
  localparam logic [2:0] StTruncated   = 3'd4;

  localparam logic CfgDispatch = 1'b0;
  localparam logic CfgPrefix   = 1'b1;

  localparam logic [7:0]  DispatchReset = 8'h7F;
  localparam logic [63:0] PrefixReset   = 64'hFE80_0000_0000_0000;
  localparam logic [63:0] Mode10Low     = 64'h0000_00FF_FE00_0000;

endpackage

// ===== rtl/core/ipv6hc_frame_ctrl.sv =====
// frame parser: phase register and header field registers, updated once per
// accepted beat; emits the finished result on the last beat; uses ipv6hc_pkg
`timescale 1ns / 1ps

module ipv6hc_frame_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              beat_i,
  input  ipv6hc_pkg::in_t   in_data_i,
  input  logic [7:0]        dispatch_value_i,
  input  logic [63:0]       prefix_i,
  output logic              res_valid_o,
  output ipv6hc_pkg::out_t  res_o
);
  import ipv6hc_pkg::*;

  logic         start_q, start_d;
  logic [3:0]   phase_q, phase_d;
  logic [4:0]   bif_q, bif_d;
  logic [15:0]  mode_q, mode_d;
  logic [31:0]  flow_q, flow_d;
  logic [7:0]   next_q, next_d;
  logic [7:0]   hop_q, hop_d;
  logic [127:0] src_q, src_d;
  logic [127:0] dst_q, dst_d;
  logic [15:0]  pay_q, pay_d;
  logic [2:0]   err_q, err_d;

  // upd_* is the state after this beat, before the end-of-frame clear
  logic [3:0]   upd_phase;
  logic [4:0]   upd_bif;
  logic [15:0]  upd_mode;
  logic [31:0]  upd_flow;
  logic [7:0]   upd_next;
  logic [7:0]   upd_hop;
  logic [127:0] upd_src;
  logic [127:0] upd_dst;
  logic [15:0]  upd_pay;
  logic [2:0]   upd_err;

  logic [7:0]   b;
  logic         skip;
  logic [1:0]   sam, dam, am;
  logic [4:0]   len, bif_inc;
  logic [3:0]   pos;
  logic [127:0] addr_w;

  function automatic logic [4:0] addr_len(input logic [1:0] m);
    logic [4:0] l;
    unique case (m)
      2'd0:    l = 5'd16;
      2'd1:    l = 5'd8;
      default: l = 5'd2;
    endcase
    return l;
  endfunction

  function automatic logic [127:0] addr_fill(input logic [1:0] m, input logic [63:0] pfx);
    logic [127:0] a;
    unique case (m)
      2'd0:    a = '0;
      2'd1:    a = {pfx, 64'd0};
      default: a = {pfx, Mode10Low};
    endcase
    return a;
  endfunction

  assign b    = in_data_i.data_byte;
  assign skip = start_q && (b == dispatch_value_i);
  assign sam  = mode_q[5:4];
  assign dam  = mode_q[1:0];
  assign am   = (phase_q == PhSrc) ? sam : dam;
  assign len  = addr_len(am);
  assign bif_inc = bif_q + 5'd1;
  assign pos  = 4'(5'd16 - len + bif_q);

  always_comb begin
    addr_w = (phase_q == PhSrc) ? src_q : dst_q;
    for (int i = 0; i < 16; i++) begin
      if (pos == 4'(i)) begin
        addr_w[(15 - i) * 8 +: 8] = addr_w[(15 - i) * 8 +: 8] | b;
      end
    end
  end

  always_comb begin
    upd_phase = phase_q;
    upd_bif   = bif_q;
    upd_mode  = mode_q;
    upd_flow  = flow_q;
    upd_next  = next_q;
    upd_hop   = hop_q;
    upd_src   = src_q;
    upd_dst   = dst_q;
    upd_pay   = pay_q;
    upd_err   = err_q;
    if (!skip) begin
      unique case (phase_q)
        PhB0: begin
          upd_mode = {b, 8'd0};
          if (b[7:5] != 3'b011) begin
            upd_err = StBadPattern; upd_phase = PhDrain;
          end else if (b[4:3] == 2'b00 || b[4:3] == 2'b10 || b[2]) begin
            upd_err = StUnsupported; upd_phase = PhDrain;
          end else begin
            unique case (b[1:0])
              2'd1:    upd_hop = 8'd1;
              2'd2:    upd_hop = 8'd64;
              2'd3:    upd_hop = 8'd255;
              default: upd_hop = 8'd0;
            endcase
            upd_phase = PhB1;
          end
        end
        PhB1: begin
          upd_mode = {mode_q[15:8], b};
          priority if (b[7] || b[6] || b[5:4] == 2'd3) begin
            upd_err = StUnsupported; upd_phase = PhDrain;
          end else if (b[3]) begin
            upd_err = StMulticast; upd_phase = PhDrain;
          end else if (b[2] || b[1:0] == 2'd3) begin
            upd_err = StUnsupported; upd_phase = PhDrain;
          end else begin
            upd_src   = addr_fill(b[5:4], prefix_i);
            upd_dst   = addr_fill(b[1:0], prefix_i);
            upd_bif   = '0;
            upd_phase = (mode_q[12:11] == 2'd1) ? PhFlow : PhNh;
          end
        end
        PhFlow: begin
          unique case (bif_q)
            5'd0: begin
              upd_flow = {4'h6, b[7:6], 6'd0, b[3:0], 16'd0};
              upd_bif  = 5'd1;
            end
            5'd1: begin
              upd_flow = flow_q | {16'd0, b, 8'd0};
              upd_bif  = 5'd2;
            end
            default: begin
              upd_flow  = flow_q | {24'd0, b};
              upd_bif   = '0;
              upd_phase = PhNh;
            end
          endcase
        end
        PhNh: begin
          upd_next  = b;
          upd_bif   = '0;
          upd_phase = (mode_q[9:8] == 2'd0) ? PhHop : PhSrc;
        end
        PhHop: begin
          upd_hop   = b;
          upd_bif   = '0;
          upd_phase = PhSrc;
        end
        PhSrc, PhDst: begin
          if (phase_q == PhSrc) upd_src = addr_w;
          else                  upd_dst = addr_w;
          upd_bif = bif_inc;
          if (bif_inc >= len) begin
            upd_bif   = '0;
            upd_phase = (phase_q == PhSrc) ? PhDst : PhPay;
          end
        end
        PhPay: begin
          if (pay_q != 16'hFFFF) upd_pay = pay_q + 16'd1;
        end
        default: ;
      endcase
    end
  end

  // result of the frame as it stands after this beat
  always_comb begin
    res_o = '0;
    if (upd_phase == PhPay) begin
      res_o.status         = StOk;
      res_o.flow_word      = upd_flow;
      res_o.payload_length = upd_pay;
      res_o.next_header    = upd_next;
      res_o.hop_limit      = upd_hop;
      res_o.source_high    = upd_src[127:64];
      res_o.source_low     = upd_src[63:0];
      res_o.dest_high      = upd_dst[127:64];
      res_o.dest_low       = upd_dst[63:0];
    end else if (upd_phase >= PhDrain) begin
      res_o.status = upd_err;
    end else begin
      res_o.status = StTruncated;
    end
  end

  assign res_valid_o = beat_i && in_data_i.last_of_frame;

  always_comb begin
    start_d = start_q;
    phase_d = phase_q;
    bif_d   = bif_q;
    mode_d  = mode_q;
    flow_d  = flow_q;
    next_d  = next_q;
    hop_d   = hop_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pay_d   = pay_q;
    err_d   = err_q;
    if (beat_i) begin
      if (in_data_i.last_of_frame) begin
        start_d = 1'b1;
        phase_d = PhB0;
        bif_d   = '0;
        mode_d  = '0;
        flow_d  = '0;
        next_d  = '0;
        hop_d   = '0;
        src_d   = '0;
        dst_d   = '0;
        pay_d   = '0;
        err_d   = StOk;
      end else begin
        start_d = 1'b0;
        phase_d = upd_phase;
        bif_d   = upd_bif;
        mode_d  = upd_mode;
        flow_d  = upd_flow;
        next_d  = upd_next;
        hop_d   = upd_hop;
        src_d   = upd_src;
        dst_d   = upd_dst;
        pay_d   = upd_pay;
        err_d   = upd_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      phase_q <= PhB0;
      bif_q   <= '0;
      mode_q  <= '0;
      flow_q  <= '0;
      next_q  <= '0;
      hop_q   <= '0;
      src_q   <= '0;
      dst_q   <= '0;
      pay_q   <= '0;
      err_q   <= StOk;
    end else begin
      start_q <= start_d;
      phase_q <= phase_d;
      bif_q   <= bif_d;
      mode_q  <= mode_d;
      flow_q  <= flow_d;
      next_q  <= next_d;
      hop_q   <= hop_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      pay_q   <= pay_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== rtl/core/ipv6hc_out_reg.sv =====
// result register: holds one finished header until the receiver takes it;
// uses ipv6hc_pkg
`timescale 1ns / 1ps

module ipv6hc_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ipv6hc_pkg::out_t  res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipv6hc_pkg::out_t  out_data_o,
  output logic              free_o
);
  import ipv6hc_pkg::*;

  logic valid_q, valid_d;
  out_t data_q, data_d;

  // free when empty or the held beat leaves this cycle
  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (free_o) valid_d = 1'b0;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/core/ipv6_header_decompressor.sv =====
// top level of the ipv6 header decompressor: configuration registers, frame
// parser and result register; uses ipv6hc_pkg, ipv6hc_frame_ctrl, ipv6hc_out_reg
`timescale 1ns / 1ps

// usage
// in channel: one frame byte per beat, last_of_frame on the final byte. a
//   leading byte equal to dispatch_value is skipped, then the two iphc bytes
//   and the inline fields are parsed; everything after is counted as payload.
// out channel: one beat per frame, issued the cycle after the last byte is
//   taken, holding status and the restored header fields.
// throughput: one input byte per cycle while in_ready_o is high; each byte
//   updates the phase register and the field registers that it covers.
// cfg channel: index 0 dispatch_value, index 1 addr_prefix (upper 64 address
//   bits); always ready, write only between frames.
// reset: parser returns to the start of a frame, the result register empties,
//   dispatch_value = 0x7f, addr_prefix = fe80::/64.
// stall: while a result waits and out_ready_i is low, in_ready_o drops; the
//   parser state and the held result stay unchanged.
module ipv6_header_decompressor (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ipv6hc_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ipv6hc_pkg::out_t  out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [63:0]       cfg_data_i
);
  import ipv6hc_pkg::*;

  logic [7:0]  dispatch_q, dispatch_d;
  logic [63:0] prefix_q, prefix_d;
  logic        beat;
  logic        res_valid;
  logic        free;
  out_t        res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;
  assign beat        = in_valid_i && free;

  always_comb begin
    dispatch_d = dispatch_q;
    prefix_d   = prefix_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgDispatch: dispatch_d = cfg_data_i[7:0];
        CfgPrefix:   prefix_d   = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dispatch_q <= DispatchReset;
      prefix_q   <= PrefixReset;
    end else begin
      dispatch_q <= dispatch_d;
      prefix_q   <= prefix_d;
    end
  end

  ipv6hc_frame_ctrl u_frame_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .beat_i           (beat),
    .in_data_i        (in_data_i),
    .dispatch_value_i (dispatch_q),
    .prefix_i         (prefix_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  ipv6hc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .free_o      (free)
  );

endmodule
